// ===== hw/rtl/sqh_pkg.sv =====
// Shared constants, types and functions for the trace classifier.
`timescale 1ns / 1ps

package sqh_pkg;

    localparam int DEFAULT_CAPACITY   = 1024;
    localparam int DEFAULT_VALUE_BITS = 16;

    localparam int VERDICT_W = 3;

    localparam logic [VERDICT_W-1:0] VERDICT_IMPOSSIBLE = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_SURE   = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_STACK      = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_QUEUE      = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_PRIORITY   = 3'd4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    localparam int CAND_STACK = 0;
    localparam int CAND_QUEUE = 1;
    localparam int CAND_HEAP  = 2;

    // Operation that every cell of one chain carries out in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD_AT_TAIL,
        CELL_SORTED_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctl_t;

    function automatic logic [VERDICT_W-1:0] verdict_of(input logic [2:0] flags);
        logic [1:0] n;
        n = 2'(flags[0]) + 2'(flags[1]) + 2'(flags[2]);
        if (n == 2'd0)
            verdict_of = VERDICT_IMPOSSIBLE;
        else if (n > 2'd1)
            verdict_of = VERDICT_NOT_SURE;
        else if (flags[CAND_STACK])
            verdict_of = VERDICT_STACK;
        else if (flags[CAND_QUEUE])
            verdict_of = VERDICT_QUEUE;
        else
            verdict_of = VERDICT_PRIORITY;
    endfunction

endpackage

// ===== hw/rtl/sqh_cell.sv =====
// One storage cell of a value chain: hold, shift either way, tail load or sorted insert.
`timescale 1ns / 1ps

module sqh_cell #(
    parameter int VALUE_BITS = sqh_pkg::DEFAULT_VALUE_BITS,
    parameter int CNT_W      = 11,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  sqh_pkg::cell_ctl_t    ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [VALUE_BITS-1:0] in_val,
    input  logic [VALUE_BITS-1:0] left_val,
    input  logic [VALUE_BITS-1:0] right_val,
    input  logic                  ge_left,
    output logic [VALUE_BITS-1:0] val,
    output logic                  ge
);
    import sqh_pkg::*;

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic                  occupied;

    assign occupied = (count > CNT_W'(INDEX));
    assign ge       = occupied && (val_reg >= in_val);
    assign val      = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            CELL_FROM_LEFT:    val_next = left_val;
            CELL_FROM_RIGHT:   val_next = right_val;
            CELL_LOAD_AT_TAIL:
            begin
                if (count == CNT_W'(INDEX))
                    val_next = in_val;
            end
            CELL_SORTED_INSERT:
            begin
                // Larger or equal values stay; the first smaller or empty slot takes the new one.
                if (ge)
                    val_next = val_reg;
                else if (ge_left)
                    val_next = in_val;
                else
                    val_next = left_val;
            end
            default:           val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== hw/rtl/sqh_chain.sv =====
// A row of value cells, each handing its value to its neighbors.
`timescale 1ns / 1ps

module sqh_chain #(
    parameter int CAPACITY   = sqh_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = sqh_pkg::DEFAULT_VALUE_BITS,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  sqh_pkg::cell_ctl_t    ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [VALUE_BITS-1:0] in_val,
    output logic [VALUE_BITS-1:0] head
);
    import sqh_pkg::*;

    logic [VALUE_BITS-1:0] vals [CAPACITY];
    logic                  ges  [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VALUE_BITS-1:0] lv;
            logic [VALUE_BITS-1:0] rv;
            logic                  gl;
            if (g == 0)
            begin : g_first
                assign lv = in_val;
                assign gl = 1'b1;
            end
            else
            begin : g_mid
                assign lv = vals[g-1];
                assign gl = ges[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_end
                assign rv = '0;
            end
            else
            begin : g_inner
                assign rv = vals[g+1];
            end
            sqh_cell #(
                .VALUE_BITS(VALUE_BITS),
                .CNT_W     (CNT_W),
                .INDEX     (g)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .count    (count),
                .in_val   (in_val),
                .left_val (lv),
                .right_val(rv),
                .ge_left  (gl),
                .val      (vals[g]),
                .ge       (ges[g])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule

// ===== hw/rtl/stack_queue_heap_trace_classifier.sv =====
// Top level of the push/take trace classifier for stack, queue and priority queue.
`timescale 1ns / 1ps

// Channel  | Signals                              | Beat
// ---------+--------------------------------------+------------------------------
// input    | in_valid, in_ready                   | cmd, value, last_of_case
// output   | out_valid, out_ready                 | verdict, final_res, overflow
//
// Chains still in play update in the cycle of acceptance, and the verdict
// appears in the output register on the next edge. The cell chains allow this:
// the stack shifts one cell either way, the queue loads at its tail and shifts
// on a take, and the priority chain is kept sorted, each cell deciding locally
// where the new value lands, so no sift over tree levels is needed.
// Reset zeroes counts and the overflow mark and sets all candidate flags; cell
// contents are only read below the count and need no reset. A new beat is taken
// whenever the output register is empty or is being emptied in the same cycle.

module stack_queue_heap_trace_classifier #(
    parameter int CAPACITY   = sqh_pkg::DEFAULT_CAPACITY,
    parameter int VALUE_BITS = sqh_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic                           last_of_case,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sqh_pkg::VERDICT_W-1:0]  verdict,
    output logic                           final_res,
    output logic                           overflow
);
    import sqh_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] lifo_count_reg, lifo_count_next;
    logic [CNT_W-1:0] fifo_count_reg, fifo_count_next;
    logic [CNT_W-1:0] heap_count_reg, heap_count_next;
    logic [2:0]       cand_reg, cand_next;
    logic             ovf_reg, ovf_next;

    logic                 out_valid_reg;
    logic [VERDICT_W-1:0] verdict_reg;
    logic                 final_reg;
    logic                 overflow_reg;

    cell_ctl_t lifo_ctl, fifo_ctl, heap_ctl;
    logic [VALUE_BITS-1:0] lifo_head, fifo_head, heap_head;
    logic in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    sqh_chain #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)) u_lifo (
        .clk(clk), .ctl(lifo_ctl), .count(lifo_count_reg), .in_val(value), .head(lifo_head)
    );
    sqh_chain #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)) u_fifo (
        .clk(clk), .ctl(fifo_ctl), .count(fifo_count_reg), .in_val(value), .head(fifo_head)
    );
    sqh_chain #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)) u_heap (
        .clk(clk), .ctl(heap_ctl), .count(heap_count_reg), .in_val(value), .head(heap_head)
    );

    // Decide per structure what its chain does with this beat.
    always_comb
    begin
        lifo_ctl.op     = CELL_HOLD;
        fifo_ctl.op     = CELL_HOLD;
        heap_ctl.op     = CELL_HOLD;
        lifo_count_next = lifo_count_reg;
        fifo_count_next = fifo_count_reg;
        heap_count_next = heap_count_reg;
        cand_next       = cand_reg;
        ovf_next        = ovf_reg;
        if (in_fire)
        begin
            if (cmd == CMD_PUSH)
            begin
                if (cand_reg[CAND_STACK])
                begin
                    if (lifo_count_reg >= CAP_CNT)
                        ovf_next = 1'b1;
                    else
                    begin
                        lifo_ctl.op     = CELL_FROM_LEFT;
                        lifo_count_next = lifo_count_reg + CNT_ONE;
                    end
                end
                if (cand_reg[CAND_QUEUE])
                begin
                    if (fifo_count_reg >= CAP_CNT)
                        ovf_next = 1'b1;
                    else
                    begin
                        fifo_ctl.op     = CELL_LOAD_AT_TAIL;
                        fifo_count_next = fifo_count_reg + CNT_ONE;
                    end
                end
                if (cand_reg[CAND_HEAP])
                begin
                    if (heap_count_reg >= CAP_CNT)
                        ovf_next = 1'b1;
                    else
                    begin
                        heap_ctl.op     = CELL_SORTED_INSERT;
                        heap_count_next = heap_count_reg + CNT_ONE;
                    end
                end
            end
            else
            begin
                if (cand_reg[CAND_STACK])
                begin
                    if (lifo_count_reg == '0 || lifo_head != value)
                        cand_next[CAND_STACK] = 1'b0;
                    else
                    begin
                        lifo_ctl.op     = CELL_FROM_RIGHT;
                        lifo_count_next = lifo_count_reg - CNT_ONE;
                    end
                end
                if (cand_reg[CAND_QUEUE])
                begin
                    if (fifo_count_reg == '0 || fifo_head != value)
                        cand_next[CAND_QUEUE] = 1'b0;
                    else
                    begin
                        fifo_ctl.op     = CELL_FROM_RIGHT;
                        fifo_count_next = fifo_count_reg - CNT_ONE;
                    end
                end
                if (cand_reg[CAND_HEAP])
                begin
                    if (heap_count_reg == '0 || heap_head != value)
                        cand_next[CAND_HEAP] = 1'b0;
                    else
                    begin
                        heap_ctl.op     = CELL_FROM_RIGHT;
                        heap_count_next = heap_count_reg - CNT_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifo_count_reg <= '0;
            fifo_count_reg <= '0;
            heap_count_reg <= '0;
            cand_reg       <= 3'b111;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire && last_of_case)
            begin
                // The closing beat reports, then the trace state starts over.
                lifo_count_reg <= '0;
                fifo_count_reg <= '0;
                heap_count_reg <= '0;
                cand_reg       <= 3'b111;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                lifo_count_reg <= lifo_count_next;
                fifo_count_reg <= fifo_count_next;
                heap_count_reg <= heap_count_next;
                cand_reg       <= cand_next;
                ovf_reg        <= ovf_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            verdict_reg  <= verdict_of(cand_next);
            final_reg    <= last_of_case;
            overflow_reg <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign final_res = final_reg;
    assign overflow  = overflow_reg;

    // No count ever passes the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        lifo_count_reg <= CAP_CNT && fifo_count_reg <= CAP_CNT && heap_count_reg <= CAP_CNT)
        else $error("store count above capacity");

    // A closing beat leaves a fresh trace behind.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_of_case |=> cand_reg == 3'b111 && !ovf_reg && lifo_count_reg == '0)
        else $error("trace state not cleared after last beat");

    // A structure once ruled out never returns within a trace.
    a_cand_mono: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !last_of_case |=> (cand_reg & ~$past(cand_reg)) == 3'b000)
        else $error("candidate flag came back");

    // Stack and queue, while both in play, hold equal counts.
    a_counts_agree: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg[CAND_STACK] && cand_reg[CAND_QUEUE] |-> lifo_count_reg == fifo_count_reg)
        else $error("candidate counts differ");

endmodule
